@@ design/multi_resource_interval_selector_core_defines.svh @@
// assertion macros for the interval selector modules
// no dependencies
`ifndef MULTI_RESOURCE_INTERVAL_SELECTOR_CORE_DEFINES_SVH
`define MULTI_RESOURCE_INTERVAL_SELECTOR_CORE_DEFINES_SVH
`define MRIS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MRIS_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`endif

@@ design/mris_pkg.sv @@
// shared constants for the interval selector
// no dependencies
package mris_pkg;
  localparam int DEF_MAX_SLOTS = 16;
  localparam int DEF_POINT_BITS = 16;
  localparam int ID_BITS = 16;
  localparam int LIM_BITS = 5;
  localparam int COST_BITS = 16;
  localparam int CNT_BITS = 16;
  localparam int TOT_BITS = 32;
  localparam logic CFG_SLOT_LIMIT = 1'b0;
  localparam logic CFG_COST = 1'b1;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_FINISH = 1'b1;
endpackage

@@ design/multi_resource_interval_selector_core.sv @@
// top level of the multi-resource interval selector
// depends on mris_pkg, mris_front and mris_back
// Greedy interval selector over up to MAX_SLOTS parallel resources. Intervals
// must enter sorted by start then end; the block does not check this. Each add
// retires finished intervals one id per cycle while the output is not stalled
// (each such id is an output word) and then inserts the new one, if a slot is
// free or in place of the latest-ending active one when that ends later. A
// finish emits the remaining ids one per cycle while the output is not stalled;
// the last of them is held for the closing state, where it goes out with last
// set and the total cost from one multiply. An empty finish gives one word with
// has_id 0, last and the total. Output stalls hold the sequencer. A two-word
// queue lets input run ahead of the sequencer.
module multi_resource_interval_selector_core #(
  parameter int MAX_SLOTS = mris_pkg::DEF_MAX_SLOTS,
  parameter int POINT_BITS = mris_pkg::DEF_POINT_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [mris_pkg::COST_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_op,
  input  logic [POINT_BITS-1:0] in_start_point,
  input  logic [POINT_BITS-1:0] in_end_point,
  input  logic [mris_pkg::ID_BITS-1:0] in_item_id,
  output logic out_valid,
  input  logic out_stall,
  output logic out_has_id,
  output logic [mris_pkg::ID_BITS-1:0] out_accepted_id,
  output logic out_last,
  output logic [mris_pkg::TOT_BITS-1:0] out_total_cost
);
  import mris_pkg::*;
  logic q_valid, q_take, q_op;
  logic [POINT_BITS-1:0] q_lo, q_hi;
  logic [ID_BITS-1:0] q_id;
  mris_front #(.POINT_BITS(POINT_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op,
    .in_lo(in_start_point), .in_hi(in_end_point), .in_id(in_item_id),
    .q_valid, .q_take, .q_op, .q_lo, .q_hi, .q_id);
  mris_back #(.MAX_SLOTS(MAX_SLOTS), .POINT_BITS(POINT_BITS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .q_valid, .q_take, .q_op, .q_lo, .q_hi, .q_id,
    .out_valid, .out_stall, .out_has_id, .out_accepted_id, .out_last,
    .out_total_cost);
endmodule

@@ design/mris_front.sv @@
// front part: accepts input words into a short queue
// depends on mris_pkg
module mris_front #(
  parameter int POINT_BITS = mris_pkg::DEF_POINT_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_op,
  input  logic [POINT_BITS-1:0] in_lo,
  input  logic [POINT_BITS-1:0] in_hi,
  input  logic [mris_pkg::ID_BITS-1:0] in_id,
  output logic q_valid,
  input  logic q_take,
  output logic q_op,
  output logic [POINT_BITS-1:0] q_lo,
  output logic [POINT_BITS-1:0] q_hi,
  output logic [mris_pkg::ID_BITS-1:0] q_id
);
  import mris_pkg::*;
  localparam int W = 1 + 2*POINT_BITS + ID_BITS;
  logic [W-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  logic [W-1:0] head;
  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign head = mem_r[rp_r];
  assign {q_op, q_lo, q_hi, q_id} = head;
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= {in_op, in_lo, in_hi, in_id};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/mris_back.sv @@
// back part: sorted active list, retirement and insertion sequencer
// depends on mris_pkg and the defines header
`include "multi_resource_interval_selector_core_defines.svh"
module mris_back #(
  parameter int MAX_SLOTS = mris_pkg::DEF_MAX_SLOTS,
  parameter int POINT_BITS = mris_pkg::DEF_POINT_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [mris_pkg::COST_BITS-1:0] cfg_data,
  input  logic q_valid,
  output logic q_take,
  input  logic q_op,
  input  logic [POINT_BITS-1:0] q_lo,
  input  logic [POINT_BITS-1:0] q_hi,
  input  logic [mris_pkg::ID_BITS-1:0] q_id,
  output logic out_valid,
  input  logic out_stall,
  output logic out_has_id,
  output logic [mris_pkg::ID_BITS-1:0] out_accepted_id,
  output logic out_last,
  output logic [mris_pkg::TOT_BITS-1:0] out_total_cost
);
  import mris_pkg::*;
  localparam int CB = $clog2(MAX_SLOTS + 1);
  localparam int IB = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LW = (CB > LIM_BITS) ? CB : LIM_BITS;
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_MUL = 2'd2;
  logic [POINT_BITS-1:0] lo_r [MAX_SLOTS];
  logic [POINT_BITS-1:0] hi_r [MAX_SLOTS];
  logic [ID_BITS-1:0] id_r [MAX_SLOTS];
  logic [CB-1:0] cnt_r;
  logic [CNT_BITS-1:0] acc_r;
  logic [LIM_BITS-1:0] lim_cfg_r;
  logic [COST_BITS-1:0] cost_r;
  logic [1:0] st_r;
  logic ov_r;
  logic fl_has_r;
  logic [ID_BITS-1:0] fl_id_r;
  logic [CB-1:0] lim;
  logic free_out, retire, fin, pop, do_ins, repl;
  logic emit_id, emit_total;
  logic [MAX_SLOTS-1:0] aft;
  logic [CB-1:0] base;
  logic [TOT_BITS-1:0] prod;

  always_comb begin
    lim = (lim_cfg_r == '0) ? CB'(1) :
          (LW'(lim_cfg_r) > LW'(MAX_SLOTS)) ? CB'(MAX_SLOTS) :
          CB'(lim_cfg_r);
  end
  assign out_valid = ov_r;
  assign free_out = !ov_r || !out_stall;
  assign fin = q_op == OP_FINISH;
  // retire head when it ends at or before the new start (or on finish)
  assign retire = (st_r == S_RUN) && cnt_r != '0 && (fin || hi_r[0] <= q_lo);
  assign pop = retire && free_out;
  // the last id of a finish goes out with the total in the closing cycle
  assign emit_id = pop && !(fin && cnt_r == CB'(1));
  assign emit_total = (st_r == S_MUL) && free_out;
  assign repl = cnt_r != '0 && hi_r[IB'(cnt_r - 1'b1)] > q_hi;
  assign do_ins = (st_r == S_RUN) && !retire && !fin && (cnt_r < lim || repl);
  assign base = (cnt_r < lim) ? cnt_r : CB'(cnt_r - 1'b1);
  assign prod = TOT_BITS'(acc_r) * TOT_BITS'(cost_r);
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++)
      aft[i] = (hi_r[i] > q_hi) || (hi_r[i] == q_hi && lo_r[i] > q_lo);
  end
  assign q_take = ((st_r == S_RUN) && !retire && !fin && free_out)
               || emit_total;

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_SLOTS - 1; i++) begin
        lo_r[i] <= lo_r[i+1]; hi_r[i] <= hi_r[i+1]; id_r[i] <= id_r[i+1];
      end
    end else if (do_ins && free_out) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (CB'(i) < base) begin
          if (aft[i] && i > 0 && !aft[i-1]) begin
            lo_r[i] <= q_lo; hi_r[i] <= q_hi; id_r[i] <= q_id;
          end else if (aft[i] && i == 0) begin
            lo_r[i] <= q_lo; hi_r[i] <= q_hi; id_r[i] <= q_id;
          end
          if (aft[i] && i + 1 < MAX_SLOTS) begin
            lo_r[(i+1)%MAX_SLOTS] <= lo_r[i]; hi_r[(i+1)%MAX_SLOTS] <= hi_r[i];
            id_r[(i+1)%MAX_SLOTS] <= id_r[i];
          end
        end else if (CB'(i) == base && (i == 0 || !aft[i-1])) begin
          lo_r[i] <= q_lo; hi_r[i] <= q_hi; id_r[i] <= q_id;
        end
      end
    end
    if (emit_id) begin
      out_has_id <= 1'b1;
      out_accepted_id <= id_r[0];
      out_last <= (!fin && (cnt_r == CB'(1) || hi_r[1] > q_lo)) ? 1'b1 : 1'b0;
      out_total_cost <= '0;
    end
    if (emit_total) begin
      out_has_id <= fl_has_r;
      out_accepted_id <= fl_id_r;
      out_last <= 1'b1;
      out_total_cost <= prod;
    end
    if (!rst_n) begin
      cnt_r <= '0; acc_r <= '0; st_r <= S_IDLE; ov_r <= 1'b0;
      fl_has_r <= 1'b0; fl_id_r <= '0;
      lim_cfg_r <= LIM_BITS'(16); cost_r <= COST_BITS'(1);
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SLOT_LIMIT) lim_cfg_r <= cfg_data[LIM_BITS-1:0];
        else cost_r <= cfg_data;
      end
      ov_r <= emit_id || emit_total || (ov_r && out_stall);
      case (st_r)
        S_IDLE: if (q_valid) st_r <= S_RUN;
        S_RUN: begin
          if (pop) begin
            cnt_r <= cnt_r - 1'b1;
            if (acc_r != '1) acc_r <= acc_r + 1'b1;
            // finish: hold the last id for the closing word with the total
            if (fin && cnt_r == CB'(1)) begin
              st_r <= S_MUL;
              fl_has_r <= 1'b1;
              fl_id_r <= id_r[0];
            end
          end else if (fin) begin
            if (!retire) begin
              st_r <= S_MUL;
              fl_has_r <= 1'b0;
              fl_id_r <= '0;
            end
          end else if (free_out) begin
            if (do_ins && cnt_r < lim) cnt_r <= cnt_r + 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_MUL: if (free_out) begin
          acc_r <= '0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MRIS_NEVER(a_cnt_range, clk, rst_n, cnt_r > CB'(MAX_SLOTS))
  `MRIS_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> cnt_r != '0)
  `MRIS_ASSERT(a_take_after_mul, clk, rst_n, (st_r == S_MUL && free_out) |=> ov_r)
endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for multi_resource_interval_selector_core
// depends on mris_pkg and the core; predicts every output word and checks in order
`timescale 1ns / 100ps

module tb;
  import mris_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] start_point;
    logic [15:0] end_point;
    logic [15:0] item_id;
  } interval_t;

  typedef struct packed {
    logic        has_id;
    logic [15:0] accepted_id;
    logic        last;
    logic [31:0] total_cost;
  } retire_word_t;

  localparam int MAXS = DEF_MAX_SLOTS;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_SLOT_LIMIT;
  logic [COST_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = OP_ADD;
  logic [15:0] in_start_point = '0;
  logic [15:0] in_end_point = '0;
  logic [15:0] in_item_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_has_id;
  logic [15:0] out_accepted_id;
  logic out_last;
  logic [31:0] out_total_cost;

  multi_resource_interval_selector_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_start_point(in_start_point), .in_end_point(in_end_point),
    .in_item_id(in_item_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_has_id(out_has_id),
    .out_accepted_id(out_accepted_id), .out_last(out_last),
    .out_total_cost(out_total_cost)
  );

  always #5 clk = ~clk;

  interval_t    pending_items[$];
  retire_word_t expected_words[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // scheduler mirror
  logic [15:0] act_lo[MAXS];
  logic [15:0] act_hi[MAXS];
  logic [15:0] act_tag[MAXS];
  int unsigned act_count = 0;
  int unsigned accepted_total = 0;
  logic [4:0]  slot_limit_reg = 5'd16;
  logic [15:0] cost_reg = 16'd1;

  function automatic void retire_front();
    for (int i = 0; i + 1 < act_count; i++) begin
      act_lo[i] = act_lo[i+1];
      act_hi[i] = act_hi[i+1];
      act_tag[i] = act_tag[i+1];
    end
    act_count--;
    if (accepted_total < 16'hFFFF) accepted_total++;
  endfunction

  function automatic void insert_by_end(logic [15:0] lo, logic [15:0] hi, logic [15:0] tag);
    int pos;
    pos = act_count;
    while (pos > 0 && (act_hi[pos-1] > hi || (act_hi[pos-1] == hi && act_lo[pos-1] > lo))) begin
      act_lo[pos] = act_lo[pos-1];
      act_hi[pos] = act_hi[pos-1];
      act_tag[pos] = act_tag[pos-1];
      pos--;
    end
    act_lo[pos] = lo;
    act_hi[pos] = hi;
    act_tag[pos] = tag;
    act_count++;
  endfunction

  function automatic void schedule_interval(interval_t it);
    int unsigned lim;
    int n;
    retire_word_t w;
    lim = slot_limit_reg;
    if (lim == 0) lim = 1;
    if (lim > MAXS) lim = MAXS;
    n = 0;
    if (it.op == OP_FINISH) begin
      while (act_count > 0) begin
        w = '{1'b1, act_tag[0], 1'b0, 32'd0};
        expected_words = {expected_words, w};
        n++;
        retire_front();
      end
      if (n == 0) begin
        w = '{1'b0, 16'd0, 1'b1, 32'(accepted_total) * 32'(cost_reg)};
        expected_words = {expected_words, w};
      end else begin
        expected_words[$].last = 1'b1;
        expected_words[$].total_cost = 32'(accepted_total) * 32'(cost_reg);
      end
      accepted_total = 0;
    end else begin
      while (act_count > 0 && act_hi[0] <= it.start_point) begin
        w = '{1'b1, act_tag[0], 1'b0, 32'd0};
        expected_words = {expected_words, w};
        n++;
        retire_front();
      end
      if (n > 0) expected_words[$].last = 1'b1;
      if (act_count < lim) begin
        insert_by_end(it.start_point, it.end_point, it.item_id);
      end else if (act_count > 0 && act_hi[act_count-1] > it.end_point) begin
        act_count--;
        insert_by_end(it.start_point, it.end_point, it.item_id);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    interval_t nx;
    if (rst_n) begin
      if (in_valid && !in_stall)
        schedule_interval('{in_op, in_start_point, in_end_point, in_item_id});
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nx = pending_items.pop_front();
          in_valid <= 1'b1;
          in_op <= nx.op;
          in_start_point <= nx.start_point;
          in_end_point <= nx.end_point;
          in_item_id <= nx.item_id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // monitor
  always @(posedge clk) begin
    retire_word_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", {31'd0, out_has_id}, 32'd0);
        end else begin
          w = expected_words.pop_front();
          if (out_has_id !== w.has_id)
            report_mismatch("has_id", {31'd0, out_has_id}, {31'd0, w.has_id});
          if (out_accepted_id !== w.accepted_id)
            report_mismatch("accepted_id", {16'd0, out_accepted_id},
                            {16'd0, w.accepted_id});
          if (out_last !== w.last)
            report_mismatch("last", {31'd0, out_last}, {31'd0, w.last});
          if (out_total_cost !== w.total_cost)
            report_mismatch("total_cost", out_total_cost, w.total_cost);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    if (idx == CFG_SLOT_LIMIT) slot_limit_reg = value[4:0];
    else cost_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void queue_item(logic op, logic [15:0] s, logic [15:0] e, logic [15:0] id);
    interval_t it;
    it = '{op, s, e, id};
    pending_items = {pending_items, it};
  endfunction

  // one sorted set of n intervals followed by a finish
  function automatic int queue_set(int n, int gap, int len);
    int s, e, ps, pe;
    s = $urandom_range(gap * 4);
    pe = 0;
    ps = -1;
    for (int i = 0; i < n; i++) begin
      s = s + $urandom_range(gap);
      if (s > 65535) s = 65535;
      e = s + $urandom_range(len);
      if (e > 65535) e = 65535;
      if (s == ps && e < pe) e = pe;
      queue_item(OP_ADD, s[15:0], e[15:0], 16'($urandom_range(16'hFFFF)));
      ps = s;
      pe = e;
    end
    queue_item(OP_FINISH, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    return n + 1;
  endfunction

  initial begin
    int sent;
    int dummy;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush, point extremes, touching ends, no-retire add
    queue_item(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_item(OP_ADD, 16'h0000, 16'h0000, 16'hFFFF);
    queue_item(OP_ADD, 16'h0000, 16'h0005, 16'h0000);
    queue_item(OP_ADD, 16'h0005, 16'h0009, 16'h1234);
    queue_item(OP_ADD, 16'h0009, 16'hFFFF, 16'hABCD);
    queue_item(OP_ADD, 16'hFFFF, 16'hFFFF, 16'h5555);
    queue_item(OP_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // slot limit zero acts as one, replacement only with earlier end
    write_reg(CFG_SLOT_LIMIT, 16'd0);
    write_reg(CFG_COST, 16'hFFFF);
    queue_item(OP_ADD, 16'd10, 16'd50, 16'd1);
    queue_item(OP_ADD, 16'd11, 16'd60, 16'd2);
    queue_item(OP_ADD, 16'd12, 16'd40, 16'd3);
    queue_item(OP_ADD, 16'd40, 16'd45, 16'd4);
    queue_item(OP_FINISH, 16'd0, 16'd0, 16'd0);
    // slot limit lowered below active count
    write_reg(CFG_SLOT_LIMIT, 16'd16);
    for (int i = 0; i < 5; i++) queue_item(OP_ADD, 16'd100, 16'(200 + i), 16'(i));
    write_reg(CFG_SLOT_LIMIT, 16'd2);
    queue_item(OP_ADD, 16'd101, 16'd150, 16'd77);
    queue_item(OP_ADD, 16'd300, 16'd301, 16'd78);
    queue_item(OP_FINISH, 16'd0, 16'd0, 16'd0);
    // unsorted input and end below start
    queue_item(OP_ADD, 16'd900, 16'd100, 16'hF0F0);
    queue_item(OP_ADD, 16'd50, 16'd60, 16'h0F0F);
    queue_item(OP_FINISH, 16'd0, 16'd0, 16'd0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 86 : 0;
      recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 21 : 0;
      for (int c = 0; c < 3; c++) begin
        case ((ph * 3 + c) % 6)
          0: begin write_reg(CFG_SLOT_LIMIT, 16'd1);  write_reg(CFG_COST, 16'd0); end
          1: begin write_reg(CFG_SLOT_LIMIT, 16'd3);  write_reg(CFG_COST, 16'd7); end
          2: begin write_reg(CFG_SLOT_LIMIT, 16'd16); write_reg(CFG_COST, 16'hFFFF); end
          3: begin write_reg(CFG_SLOT_LIMIT, 16'd31); write_reg(CFG_COST, 16'd1); end
          4: begin write_reg(CFG_SLOT_LIMIT, 16'd17); write_reg(CFG_COST, 16'(1 << $urandom_range(15))); end
          default: begin
            write_reg(CFG_SLOT_LIMIT, 16'($urandom_range(31)));
            write_reg(CFG_COST, 16'($urandom_range(16'hFFFF)));
          end
        endcase
        sent = 0;
        while (sent < 45) begin
          if ($urandom_range(9) == 0) begin
            // noise: unordered full-range items
            for (int k = 0; k < 3; k++)
              queue_item(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                         16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
            sent += 3;
          end else if ($urandom_range(7) == 0) begin
            // long set with wide gaps and lengths
            dummy = queue_set($urandom_range(20, 30), 2000, 30000);
            sent += dummy;
          end else begin
            dummy = queue_set($urandom_range(1, 12), $urandom_range(1, 20),
                              $urandom_range(0, 60));
            sent += dummy;
          end
          while (pending_items.size() > 8) @(posedge clk);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/mris_pkg.sv
design/mris_front.sv
design/mris_back.sv
design/multi_resource_interval_selector_core.sv
tb/sv/tb.sv
